### hw/rtl/cse_pkg.sv
package cse_pkg;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_PRINT_LO  = 8'h21;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NONE      = 8'h00;

    localparam logic [1:0] LAST_PLAIN  = 2'd0;
    localparam logic [1:0] LAST_LETTER = 2'd1;
    localparam logic [1:0] LAST_OCTAL  = 2'd3;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            esc;
    } expand_t;

    function automatic logic [7:0] esc_letter(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h07:   r = 8'h61;
            8'h08:   r = 8'h62;
            8'h0C:   r = 8'h66;
            8'h0A:   r = 8'h6E;
            8'h0D:   r = 8'h72;
            8'h09:   r = 8'h74;
            8'h0B:   r = 8'h76;
            8'h22:   r = CH_DQUOTE;
            8'h27:   r = CH_SQUOTE;
            8'h1B:   r = 8'h65;
            default: r = CH_NONE;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/cse_encode.sv
module cse_encode (
    input  logic [7:0]       char_in,
    output cse_pkg::expand_t x
);

    logic       plain;
    logic [7:0] letter;

    assign plain = (char_in == cse_pkg::CH_SPACE)
                || (char_in >= cse_pkg::CH_PRINT_LO && char_in <= cse_pkg::CH_PRINT_HI
                    && char_in != cse_pkg::CH_BACKSLASH
                    && char_in != cse_pkg::CH_DQUOTE
                    && char_in != cse_pkg::CH_SQUOTE);

    assign letter = cse_pkg::esc_letter(char_in);

    always_comb begin
        x.bytes[1] = cse_pkg::CH_ZERO + {6'd0, char_in[7:6]};
        x.bytes[2] = cse_pkg::CH_ZERO + {5'd0, char_in[5:3]};
        x.bytes[3] = cse_pkg::CH_ZERO + {5'd0, char_in[2:0]};
        if (plain) begin
            x.bytes[0] = char_in;
            x.last_idx = cse_pkg::LAST_PLAIN;
            x.esc      = 1'b0;
        end else if (letter != cse_pkg::CH_NONE) begin
            x.bytes[0] = cse_pkg::CH_BACKSLASH;
            x.bytes[1] = letter;
            x.last_idx = cse_pkg::LAST_LETTER;
            x.esc      = 1'b1;
        end else begin
            x.bytes[0] = cse_pkg::CH_BACKSLASH;
            x.last_idx = cse_pkg::LAST_OCTAL;
            x.esc      = 1'b1;
        end
    end

endmodule

### hw/rtl/cse_emit.sv
module cse_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_end,
    input  cse_pkg::expand_t x,
    output logic             in_done,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_char_out,
    output logic             m_run_last,
    output logic             m_string_last,
    output logic             m_any_escaped
);

    logic       m_valid_reg, m_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       seen_reg, seen_next;
    logic [7:0] char_reg;
    logic       run_last_reg, string_last_reg, any_reg;
    logic       load, is_last;

    assign load    = in_valid && (!m_valid_reg || m_ready);
    assign is_last = (idx_reg == x.last_idx);
    assign in_done = load && is_last;

    always_comb begin
        m_valid_next = load || (m_valid_reg && !m_ready);
        idx_next     = idx_reg;
        seen_next    = seen_reg;
        if (in_done) begin
            idx_next  = 2'd0;
            seen_next = in_end ? 1'b0 : (seen_reg || x.esc);
        end else if (load) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
            seen_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg        <= x.bytes[idx_reg];
            run_last_reg    <= is_last;
            string_last_reg <= is_last && in_end;
            any_reg         <= is_last && in_end && (seen_reg || x.esc);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_char_out    = char_reg;
    assign m_run_last    = run_last_reg;
    assign m_string_last = string_last_reg;
    assign m_any_escaped = any_reg;

`ifndef SYNTHESIS
    a_any_on_string_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && any_reg |-> string_last_reg)
        else $error("any_escaped set off the string's final byte");
    a_string_last_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && string_last_reg |-> run_last_reg)
        else $error("string_last without run_last");
    a_idx_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        in_done |=> idx_reg == 2'd0)
        else $error("byte index did not return to zero");
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |-> idx_reg <= x.last_idx)
        else $error("byte index past the expansion");
    a_seen_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        in_done && in_end |=> !seen_reg)
        else $error("escape flag kept across strings");
`endif

endmodule

### hw/rtl/c_string_escape_encoder.sv
// C string literal escape encoder. Bytes of a string enter on s_char_in with
// s_string_end on the final byte; escaped text leaves one byte per cycle on
// m_char_out while m_ready is high. An input byte yields one output byte
// (plain), two (backslash and letter or quote) or four (backslash and three
// octal digits), each held in turn in the single output register; plain bytes
// stream at one per cycle while m_ready is high, and the next input is taken
// in the cycle the previous one's last output byte is loaded. Each input byte
// is registered, then each of its result bytes, before being presented.
// m_run_last marks the last byte from each input byte, m_string_last the last
// byte of the string, and m_any_escaped, valid with m_string_last, tells
// whether any byte of the string needed escaping.
module c_string_escape_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_string_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic       m_run_last,
    output logic       m_string_last,
    output logic       m_any_escaped
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_char_reg;
    logic             in_end_reg;
    logic             in_done;
    cse_pkg::expand_t x;

    assign s_ready = !in_valid_reg || in_done;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_done) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
            in_end_reg  <= s_string_end;
        end
    end

    cse_encode u_encode (
        .char_in (in_char_reg),
        .x       (x)
    );

    cse_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (in_valid_reg),
        .in_end        (in_end_reg),
        .x             (x),
        .in_done       (in_done),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_out    (m_char_out),
        .m_run_last    (m_run_last),
        .m_string_last (m_string_last),
        .m_any_escaped (m_any_escaped)
    );

endmodule

### sim/tb_c_string_escape_encoder.sv
module tb_c_string_escape_encoder;

    localparam int CLK_HIGH     = 10;
    localparam int CLK_LOW      = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_IDLE     = 13;
    localparam int MAX_STR_LEN  = 12;
    localparam int SETTLE       = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 22;
    localparam int NUM_SPECIAL  = 11;

    localparam logic [7:0] C_BEL = 8'h07;
    localparam logic [7:0] C_BS  = 8'h08;
    localparam logic [7:0] C_HT  = 8'h09;
    localparam logic [7:0] C_LF  = 8'h0A;
    localparam logic [7:0] C_VT  = 8'h0B;
    localparam logic [7:0] C_FF  = 8'h0C;
    localparam logic [7:0] C_CR  = 8'h0D;
    localparam logic [7:0] C_ESC = 8'h1B;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic       string_last;
        logic       any_escaped;
    } text_beat_t;

    // typed_n of zero: take the expected text from the predictor
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic [2:0]  typed_n;
        logic [31:0] typed_seq;
        logic        typed_any;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b0, 3'd4, "\\000", 1'b0},
        '{8'hFF, 1'b1, 3'd4, "\\377", 1'b1},
        '{8'h20, 1'b1, 3'd1, " ",     1'b0},
        '{8'h5C, 1'b1, 3'd4, "\\134", 1'b1},
        '{8'h21, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h7E, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h7F, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h22, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h27, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h07, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h08, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h0C, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h0A, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h0D, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h09, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h0B, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h1B, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h80, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h1F, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h41, 1'b1, 3'd0, 32'h0,   1'b0},
        '{8'h48, 1'b0, 3'd0, 32'h0,   1'b0},
        '{8'h69, 1'b1, 3'd0, 32'h0,   1'b0}
    };

    localparam logic [7:0] SPECIALS [NUM_SPECIAL] = '{
        C_BEL, C_BS, C_HT, C_LF, C_VT, C_FF, C_CR, C_ESC,
        cse_pkg::CH_BACKSLASH, cse_pkg::CH_DQUOTE, cse_pkg::CH_SQUOTE
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       s_string_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_char_out;
    logic       m_run_last;
    logic       m_string_last;
    logic       m_any_escaped;

    text_beat_t  escaped_text[$];
    text_beat_t  want_beat;
    logic        string_escaped = 1'b0;
    bit          source_calm = 1'b0;
    bit          sink_calm = 1'b0;
    int unsigned sink_wait = 0;
    int unsigned mismatches = 0;
    int unsigned beats_seen = 0;
    int unsigned cycle_count = 0;

    c_string_escape_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_in     (s_char_in),
        .s_string_end  (s_string_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_out    (m_char_out),
        .m_run_last    (m_run_last),
        .m_string_last (m_string_last),
        .m_any_escaped (m_any_escaped)
    );

    always begin
        #CLK_HIGH aclk = 1'b1;
        #CLK_LOW  aclk = 1'b0;
    end

    function automatic int expand_char(input logic [7:0] c, output logic [3:0][7:0] seq);
        logic [7:0] letter;
        seq = '0;
        unique case (c)
            C_BEL:   letter = "a";
            C_BS:    letter = "b";
            C_FF:    letter = "f";
            C_LF:    letter = "n";
            C_CR:    letter = "r";
            C_HT:    letter = "t";
            C_VT:    letter = "v";
            C_ESC:   letter = "e";
            cse_pkg::CH_DQUOTE, cse_pkg::CH_SQUOTE: letter = c;
            default: letter = cse_pkg::CH_NONE;
        endcase
        if (c == cse_pkg::CH_SPACE || (c >= cse_pkg::CH_PRINT_LO && c <= cse_pkg::CH_PRINT_HI
                && c != cse_pkg::CH_BACKSLASH && letter == cse_pkg::CH_NONE)) begin
            seq[0] = c;
            return 1;
        end
        seq[0] = cse_pkg::CH_BACKSLASH;
        if (letter != cse_pkg::CH_NONE) begin
            seq[1] = letter;
            return 2;
        end
        seq[1] = cse_pkg::CH_ZERO + {6'd0, c[7:6]};
        seq[2] = cse_pkg::CH_ZERO + {5'd0, c[5:3]};
        seq[3] = cse_pkg::CH_ZERO + {5'd0, c[2:0]};
        return 4;
    endfunction

    task automatic predict_char(input logic [7:0] c, input logic fin,
                                output logic [3:0][7:0] seq, output int n,
                                output logic any);
        n = expand_char(c, seq);
        if (n > 1)
            string_escaped = 1'b1;
        any = fin && string_escaped;
        if (fin)
            string_escaped = 1'b0;
    endtask

    task automatic queue_text(input logic [3:0][7:0] seq, input int n, input logic fin,
                              input logic any);
        text_beat_t b;
        for (int k = 0; k < n; k++) begin
            b.char_out    = seq[k];
            b.run_last    = (k == n - 1);
            b.string_last = (k == n - 1) && fin;
            b.any_escaped = (k == n - 1) && fin && any;
            escaped_text.push_back(b);
        end
    endtask

    function automatic logic [7:0] draw_char(input bit plain_only);
        logic [7:0]  c;
        int unsigned pick;
        if (plain_only) begin
            do
                c = 8'($urandom_range(cse_pkg::CH_SPACE, cse_pkg::CH_PRINT_HI));
            while (c == cse_pkg::CH_BACKSLASH || c == cse_pkg::CH_DQUOTE
                   || c == cse_pkg::CH_SQUOTE);
            return c;
        end
        pick = $urandom_range(0, 9);
        if (pick < 5)
            c = 8'($urandom_range(cse_pkg::CH_SPACE, cse_pkg::CH_PRINT_HI));
        else if (pick < 7)
            c = SPECIALS[$urandom_range(0, NUM_SPECIAL - 1)];
        else
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic fin);
        int unsigned gap;
        gap = source_calm ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_char_in    = c;
        s_string_end = fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("mismatch on result %0d, %s: want %0h got %0h", beats_seen, field, want, got);
        mismatches++;
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (sink_wait != 0) begin
            m_ready = 1'b0;
            sink_wait--;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (escaped_text.size() == 0) begin
                report_mismatch("unexpected transaction", 0, m_char_out);
            end else begin
                want_beat = escaped_text.pop_front();
                if (m_char_out !== want_beat.char_out)
                    report_mismatch("char_out", want_beat.char_out, m_char_out);
                if (m_run_last !== want_beat.run_last)
                    report_mismatch("run_last", want_beat.run_last, m_run_last);
                if (m_string_last !== want_beat.string_last)
                    report_mismatch("string_last", want_beat.string_last, m_string_last);
                if (m_any_escaped !== want_beat.any_escaped)
                    report_mismatch("any_escaped", want_beat.any_escaped, m_any_escaped);
            end
            beats_seen++;
            sink_wait = sink_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [3:0][7:0] seq;
        logic [7:0]      c;
        logic            any;
        logic            fin;
        int              n;
        int              len;
        int              sent;
        bit              plain_only;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_char(DIR_TABLE[r].ch, DIR_TABLE[r].fin);
            predict_char(DIR_TABLE[r].ch, DIR_TABLE[r].fin, seq, n, any);
            if (DIR_TABLE[r].typed_n != 0) begin
                n = DIR_TABLE[r].typed_n;
                for (int k = 0; k < n; k++)
                    seq[k] = DIR_TABLE[r].typed_seq[8 * (n - 1 - k) +: 8];
                any = DIR_TABLE[r].typed_any;
            end
            queue_text(seq, n, DIR_TABLE[r].fin, any);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len        = $urandom_range(1, MAX_STR_LEN);
            plain_only = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                source_calm = !source_calm;
            for (int k = 0; k < len; k++) begin
                c   = draw_char(plain_only);
                fin = (k == len - 1);
                send_char(c, fin);
                predict_char(c, fin, seq, n, any);
                queue_text(seq, n, fin, any);
                sent++;
                if (sent == RANDOM_ITEMS / 2) begin
                    // hold off until the output side has caught up
                    drop_valid();
                    while (escaped_text.size() != 0) @(posedge aclk);
                end
            end
        end

        drop_valid();
        while (escaped_text.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
